/* sv/bcd_rtc_to_day_tick_serial_defines.svh */
// ----------------------------------------------------------------------------
// bcd_rtc_to_day_tick_serial_defines.svh
// Assertion macros shared by the checker of the rtc tick serial block
// ----------------------------------------------------------------------------
`ifndef BCD_RTC_TO_DAY_TICK_SERIAL_DEFINES_SVH
`define BCD_RTC_TO_DAY_TICK_SERIAL_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define BRTD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BRTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/brtd_pkg.sv */
// ----------------------------------------------------------------------------
// brtd_pkg
// Widths, constants and tables for the rtc to tick serial block
// ----------------------------------------------------------------------------
package brtd_pkg;

  localparam int IN_W  = 48;
  localparam int OUT_W = 120;

  // integer constants of the day number and tick serial formulas
  localparam logic [11:0] YEAR_BASE     = 12'd2000;
  localparam logic [12:0] YEAR_EPOCH    = 13'd6800;   // 2000 + 4800
  localparam logic [23:0] DAYS_PER_4Y   = 24'd1461;
  localparam logic [23:0] JD_BIAS       = 24'd32075;
  localparam logic [5:0]  CENTURY_CORR  = 6'd51;
  localparam logic [47:0] TICKS_PER_DAY = 48'd88473600;

  typedef struct packed {
    logic [21:0] julian_day;
    logic [17:0] tod_sec;      // hour*3600 + minute*60 + second
    logic [11:0] year_bin;
    logic [4:0]  month_bin;
    logic [5:0]  day_bin;
    logic [5:0]  hour_bin;
    logic [6:0]  minute_bin;
    logic [6:0]  second_bin;
  } brtd_fields_t;

  // floor(367 * shifted_month / 12), jan/feb counted as shifted months 11 and 12
  function automatic logic [9:0] month_offset(input logic [4:0] m);
    logic [9:0] v;
    begin
      case (m)
        5'd0:    v = 10'd305;
        5'd1:    v = 10'd336;
        5'd2:    v = 10'd367;
        5'd3:    v = 10'd30;
        5'd4:    v = 10'd61;
        5'd5:    v = 10'd91;
        5'd6:    v = 10'd122;
        5'd7:    v = 10'd152;
        5'd8:    v = 10'd183;
        5'd9:    v = 10'd214;
        5'd10:   v = 10'd244;
        5'd11:   v = 10'd275;
        5'd12:   v = 10'd305;
        5'd13:   v = 10'd336;
        5'd14:   v = 10'd367;
        5'd15:   v = 10'd397;
        5'd16:   v = 10'd428;
        5'd17:   v = 10'd458;
        5'd18:   v = 10'd489;
        5'd19:   v = 10'd519;
        5'd20:   v = 10'd550;
        5'd21:   v = 10'd581;
        5'd22:   v = 10'd611;
        5'd23:   v = 10'd642;
        5'd24:   v = 10'd672;
        5'd25:   v = 10'd703;
        default: v = 10'd0;
      endcase
      return v;
    end
  endfunction

endpackage

/* sv/bcd_rtc_to_day_tick_serial.sv */
// ----------------------------------------------------------------------------
// bcd_rtc_to_day_tick_serial
// BCD real-time-clock snapshot to Julian day number and 1/1024 s tick serial
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction carries the six BCD clock registers (sec, min,
//           hour, day, month, two-digit year) packed in in_tdata.
//   out_* : one transaction per input, carrying the tick serial, the Julian
//           day number and the six decoded binary fields.
//   Three register stages: input capture, decode and day number, then the
//   day-times-ticks multiply and final sum. An accepted transaction passes
//   them in that order to out_tvalid; one transaction per cycle is sustained
//   while out_tready stays high. The single 22x27 constant multiply in the
//   last stage sets the clock period.
//   Reset clears the stage valid bits only; no output is shown afterwards
//   until a new transaction has gone through.
//   When the receiver holds out_tready low the output holds; stages behind
//   it keep filling empty slots, and in_tready drops once all are full.
// ----------------------------------------------------------------------------
module bcd_rtc_to_day_tick_serial (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // sec_bcd[7:0], min_bcd[15:8], hour_bcd[23:16], day_bcd[31:24],
  // month_bcd[39:32], year_bcd[47:40]
  input  logic [brtd_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // tick_serial[47:0], julian_day[69:48], year_bin[81:70], month_bin[86:82],
  // day_bin[92:87], hour_bin[98:93], minute_bin[105:99], second_bin[112:106],
  // zero[119:113]
  output logic [brtd_pkg::OUT_W-1:0] out_tdata
);

  logic                       s0_vld_r;
  logic [brtd_pkg::IN_W-1:0]  s0_raw_r;
  logic                       s1_vld_r;
  brtd_pkg::brtd_fields_t     s1_fld_r;
  brtd_pkg::brtd_fields_t     s1_fld_nxt;
  logic                       out_vld_r;
  logic [brtd_pkg::OUT_W-1:0] out_data_r;
  logic [brtd_pkg::OUT_W-1:0] out_data_nxt;

  logic en0, en1, en2;

  // a stage moves when it is empty or the one after it moves
  assign en2 = !out_vld_r || out_tready;
  assign en1 = !s1_vld_r || en2;
  assign en0 = !s0_vld_r || en1;

  assign in_tready  = en0;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // decode and day number
  logic [6:0]  sec_dec, min_dec;
  logic [5:0]  hour_dec, day_dec;
  logic [4:0]  mon_dec;
  logic [7:0]  yy_dec;
  logic        early;
  logic [12:0] yx;
  logic [23:0] t1_full;
  logic [9:0]  t2;
  logic        century;
  logic [5:0]  t3;
  logic [23:0] jd_full;
  logic [17:0] tod;

  always_comb begin
    sec_dec  = {3'b0, s0_raw_r[3:0]}   + {4'b0, s0_raw_r[6:4]} * 7'd10;
    min_dec  = {3'b0, s0_raw_r[11:8]}  + {4'b0, s0_raw_r[14:12]} * 7'd10;
    hour_dec = {2'b0, s0_raw_r[19:16]} + {4'b0, s0_raw_r[21:20]} * 6'd10;
    day_dec  = {2'b0, s0_raw_r[27:24]} + {4'b0, s0_raw_r[29:28]} * 6'd10;
    mon_dec  = {1'b0, s0_raw_r[35:32]} + {4'b0, s0_raw_r[36]} * 5'd10;
    yy_dec   = {4'b0, s0_raw_r[43:40]} + {4'b0, s0_raw_r[47:44]} * 8'd10;

    // jan and feb belong to the previous year
    early   = (mon_dec <= 5'd2);
    yx      = brtd_pkg::YEAR_EPOCH + {5'b0, yy_dec} - {12'b0, early};
    t1_full = {11'b0, yx} * brtd_pkg::DAYS_PER_4Y;
    t2      = brtd_pkg::month_offset(mon_dec);
    // shifted year 2100 and up adds one to the century correction
    century = early ? (yy_dec >= 8'd101) : (yy_dec >= 8'd100);
    t3      = brtd_pkg::CENTURY_CORR + {5'b0, century};
    jd_full = {2'b0, t1_full[23:2]} + {14'b0, t2} + {18'b0, day_dec}
            - {18'b0, t3} - brtd_pkg::JD_BIAS;

    tod = {12'b0, hour_dec} * 18'd3600 + {11'b0, min_dec} * 18'd60
        + {11'b0, sec_dec};

    s1_fld_nxt.julian_day = jd_full[21:0];
    s1_fld_nxt.tod_sec    = tod;
    s1_fld_nxt.year_bin   = brtd_pkg::YEAR_BASE + {4'b0, yy_dec};
    s1_fld_nxt.month_bin  = mon_dec;
    s1_fld_nxt.day_bin    = day_dec;
    s1_fld_nxt.hour_bin   = hour_dec;
    s1_fld_nxt.minute_bin = min_dec;
    s1_fld_nxt.second_bin = sec_dec;
  end

  // tick serial
  logic [47:0] tick;

  always_comb begin
    tick = {26'b0, s1_fld_r.julian_day} * brtd_pkg::TICKS_PER_DAY
         + {20'b0, s1_fld_r.tod_sec, 10'b0};
    out_data_nxt = {7'b0, s1_fld_r.second_bin, s1_fld_r.minute_bin, s1_fld_r.hour_bin,
                    s1_fld_r.day_bin, s1_fld_r.month_bin, s1_fld_r.year_bin,
                    s1_fld_r.julian_day, tick};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (en0) begin
        s0_vld_r <= in_tvalid;
      end
      if (en1) begin
        s1_vld_r <= s0_vld_r;
      end
      if (en2) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_tvalid) begin
      s0_raw_r <= in_tdata;
    end
    if (en1 && s0_vld_r) begin
      s1_fld_r <= s1_fld_nxt;
    end
    if (en2 && s1_vld_r) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* sv/brtd_checker.sv */
// ----------------------------------------------------------------------------
// brtd_checker
// Port-level checks on the rtc to tick serial block, bound to its top level
// ----------------------------------------------------------------------------
`include "bcd_rtc_to_day_tick_serial_defines.svh"

module brtd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [brtd_pkg::IN_W-1:0]  in_tdata,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [brtd_pkg::OUT_W-1:0] out_tdata
);

  // a waiting input transaction holds its payload
  `BRTD_ASSERT_NEXT(a_in_hold, in_tvalid && !in_tready,
                    in_tvalid && $stable(in_tdata), "input changed while waiting")

  // a stalled output transaction holds its payload
  `BRTD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata), "output changed while stalled")

  // every term of the serial is a whole second of ticks
  `BRTD_ASSERT_NOW(a_tick_whole_sec, out_tvalid, out_tdata[9:0] == 10'd0,
                   "tick serial has sub-second bits")

  `BRTD_ASSERT_NOW(a_year_range, out_tvalid,
                   out_tdata[81:70] >= 12'd2000 && out_tdata[81:70] <= 12'd2165,
                   "year out of range")

  `BRTD_ASSERT_NOW(a_pad_zero, out_tvalid,
                   out_tdata[119:113] == 7'd0 && out_tdata[86:82] <= 5'd25,
                   "bad padding or month")

endmodule

bind bcd_rtc_to_day_tick_serial brtd_checker u_brtd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* test/tb_bcd_rtc_to_day_tick_serial_checker.sv */
// ----------------------------------------------------------------------------
// tb_bcd_rtc_to_day_tick_serial_checker
// Watches both stream channels of the rtc tick serial block, works out the
// day number and tick serial of every accepted clock snapshot, and compares
// each output transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bcd_rtc_to_day_tick_serial_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [brtd_pkg::IN_W-1:0]  in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [brtd_pkg::OUT_W-1:0] out_tdata,
  output int                         fail_count,
  output int                         results_due
);

  // out_tdata layout, most significant field first
  typedef struct packed {
    logic [6:0]  pad;
    logic [6:0]  second_bin;
    logic [6:0]  minute_bin;
    logic [5:0]  hour_bin;
    logic [5:0]  day_bin;
    logic [4:0]  month_bin;
    logic [11:0] year_bin;
    logic [21:0] julian_day;
    logic [47:0] tick_serial;
  } tick_result_t;

  tick_result_t serial_q[$];

  initial begin
    fail_count  = 0;
    results_due = 0;
  end

  function automatic longint bcd_value(input logic [3:0] units, input logic [3:0] tens);
    return longint'(units) + 10 * longint'(tens);
  endfunction

  function automatic tick_result_t rtc_serial_of(input logic [brtd_pkg::IN_W-1:0] regs);
    tick_result_t r;
    longint sec, mnt, hr, dy, mon, yr, feb_adj, jd, serial;
    sec = bcd_value(regs[3:0],   {1'b0, regs[6:4]});
    mnt = bcd_value(regs[11:8],  {1'b0, regs[14:12]});
    hr  = bcd_value(regs[19:16], {2'b0, regs[21:20]});
    dy  = bcd_value(regs[27:24], {2'b0, regs[29:28]});
    mon = bcd_value(regs[35:32], {3'b0, regs[36]});
    yr  = 2000 + bcd_value(regs[43:40], regs[47:44]);
    // january and february count as months of the previous year
    feb_adj = (mon <= 2) ? -1 : 0;
    jd = dy - 32075
       + 1461 * (yr + 4800 + feb_adj) / 4
       + 367 * (mon - 2 - feb_adj * 12) / 12
       - 3 * ((yr + 4900 + feb_adj) / 100) / 4;
    if (jd < 0) jd = 0;
    serial = jd * 88473600 + hr * 3686400 + mnt * 61440 + sec * 1024;
    r             = '0;
    r.tick_serial = serial[47:0];
    r.julian_day  = jd[21:0];
    r.year_bin    = yr[11:0];
    r.month_bin   = mon[4:0];
    r.day_bin     = dy[5:0];
    r.hour_bin    = hr[5:0];
    r.minute_bin  = mnt[6:0];
    r.second_bin  = sec[6:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (serial_q.size() == 0) begin
          report_mismatch("unexpected output transaction", got.tick_serial, 0);
        end else begin
          want = serial_q.pop_front();
          if (got.tick_serial !== want.tick_serial)
            report_mismatch("tick_serial", got.tick_serial, want.tick_serial);
          if (got.julian_day !== want.julian_day)
            report_mismatch("julian_day", got.julian_day, want.julian_day);
          if (got.year_bin !== want.year_bin)
            report_mismatch("year_bin", got.year_bin, want.year_bin);
          if (got.month_bin !== want.month_bin)
            report_mismatch("month_bin", got.month_bin, want.month_bin);
          if (got.day_bin !== want.day_bin)
            report_mismatch("day_bin", got.day_bin, want.day_bin);
          if (got.hour_bin !== want.hour_bin)
            report_mismatch("hour_bin", got.hour_bin, want.hour_bin);
          if (got.minute_bin !== want.minute_bin)
            report_mismatch("minute_bin", got.minute_bin, want.minute_bin);
          if (got.second_bin !== want.second_bin)
            report_mismatch("second_bin", got.second_bin, want.second_bin);
          if (got.pad !== want.pad)
            report_mismatch("padding bits", got.pad, want.pad);
        end
      end
      if (in_tvalid && in_tready) begin
        serial_q.push_back(rtc_serial_of(in_tdata));
      end
      results_due <= serial_q.size();
    end
  end

endmodule

/* test/tb_bcd_rtc_to_day_tick_serial.sv */
// ----------------------------------------------------------------------------
// tb_bcd_rtc_to_day_tick_serial
// Drives BCD clock snapshots into the rtc tick serial block: a directed set
// of calendar corners and bad digits, then mostly valid random dates mixed
// with raw register noise, under random idling on both sides, a long output
// hold and a full drain. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bcd_rtc_to_day_tick_serial;

  localparam int RANDOM_ITEMS = 1480;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 150;
  localparam int HOLD_AFTER   = 300;
  localparam int TAIL_CYCLES  = 10;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [brtd_pkg::IN_W-1:0]  in_tdata   = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [brtd_pkg::OUT_W-1:0] out_tdata;

  logic calm    = 1'b0;  // no idling on either side while set
  logic rx_hold = 1'b0;
  int   sent    = 0;
  int   cycles  = 0;
  int   fail_count;
  int   results_due;

  always #2 clk = ~clk;

  bcd_rtc_to_day_tick_serial dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tb_bcd_rtc_to_day_tick_serial_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold) begin
      out_tready <= 1'b0;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 9);
    end
  end

  // long receiver stall while the sender keeps offering
  initial begin
    while (sent < HOLD_AFTER) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic logic [7:0] to_bcd(input int v);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  function automatic logic [brtd_pkg::IN_W-1:0] pack_clock(input logic [7:0] yr, mon, dy,
                                                           hr, mnt, sec);
    return {yr, mon, dy, hr, mnt, sec};
  endfunction

  function automatic logic [brtd_pkg::IN_W-1:0] random_snapshot();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    if ($urandom_range(99) < 30) begin
      return raw[brtd_pkg::IN_W-1:0];
    end
    return pack_clock(to_bcd($urandom_range(99)), to_bcd($urandom_range(1, 12)),
                      to_bcd($urandom_range(1, 31)), to_bcd($urandom_range(23)),
                      to_bcd($urandom_range(59)), to_bcd($urandom_range(59)));
  endfunction

  task automatic send_item(input logic [brtd_pkg::IN_W-1:0] regs);
    while (!calm && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= regs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  initial begin
    logic [brtd_pkg::IN_W-1:0] corners[$];
    corners = '{
      '0,
      '1,
      pack_clock(8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00),
      pack_clock(8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59),
      // month zero and one, both on the jan/feb branch
      pack_clock(8'h25, 8'h00, 8'h10, 8'h12, 8'h30, 8'h30),
      pack_clock(8'h25, 8'h01, 8'h31, 8'h06, 8'h07, 8'h08),
      pack_clock(8'h24, 8'h02, 8'h29, 8'h11, 8'h11, 8'h11),
      pack_clock(8'h24, 8'h03, 8'h01, 8'h00, 8'h00, 8'h01),
      pack_clock(8'h00, 8'h02, 8'h29, 8'h23, 8'h59, 8'h59),
      pack_clock(8'h99, 8'h02, 8'h28, 8'h01, 8'h02, 8'h03),
      pack_clock(8'h50, 8'h12, 8'h01, 8'h00, 8'h00, 8'h00),
      // largest values the digit masks allow, bad bcd digits included
      pack_clock(8'hFF, 8'h1F, 8'h3F, 8'h3F, 8'h7F, 8'h7F),
      pack_clock(8'hAF, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F),
      pack_clock(8'hF0, 8'h10, 8'h30, 8'h30, 8'h70, 8'h70),
      // bits outside the digit masks must be ignored
      pack_clock(8'h07, 8'hE6, 8'hC5, 8'hC3, 8'h80, 8'h80),
      pack_clock(8'h00, 8'hE0, 8'hC0, 8'hC0, 8'h80, 8'h80),
      pack_clock(8'h38, 8'h07, 8'h04, 8'h20, 8'h45, 8'h15)
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corners[i]) send_item(corners[i]);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 500) calm <= 1'b1;
      if (i == 800) calm <= 1'b0;
      if (i == 1000) wait_drained();
      send_item(random_snapshot());
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
